// File: hw/rtl/heat_diffusion_stencil_2d_macros.svh
// Assertion macros used by the checker file.
`ifndef HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HDS_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HDS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/hds_pkg.sv
// Package with the shared types and constants of the heat diffusion block.
`timescale 1ns / 1ps
package hds_pkg;
   localparam int GRID = 64;
   localparam int IDX_W = $clog2(GRID);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int SIZE_W = 7;
   localparam int STEP_W = 24;
   localparam int COEF_W = 16;
   localparam int TEMP_W = 32;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;

   localparam logic [1:0] CSR_GRID_SIZE  = 2'd0;
   localparam logic [1:0] CSR_STEP_COUNT = 2'd1;
   localparam logic [1:0] CSR_COEF_X     = 2'd2;
   localparam logic [1:0] CSR_COEF_Y     = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_COPY, ST_CP_LAST, ST_FETCH, ST_CALC, ST_MUL, ST_SUM,
      ST_WRITE, ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             copy_rd;
      logic             copy_wr;
      logic             fetch;
      logic [2:0]       fetch_sel;
      logic             calc;
      logic             mul;
      logic             sum;
      logic             write_back;
      logic [ADDR_W-1:0] copy_addr;
      logic [IDX_W-1:0] cell_row;
      logic [IDX_W-1:0] cell_col;
   } cmd_type;
endpackage

// File: hw/rtl/heat_diffusion_stencil_2d.sv
// Top level of the two-dimensional heat diffusion block.
`timescale 1ns / 1ps
// A cell write leaves the block idle for the next item; a cell read passes through the
// current-grid read register and then the result register. Each sweep of a run first
// copies the whole 4096-cell current grid into the previous-sweep memory and then takes
// each interior cell in steps: five fetches of the stencil cells in turn through the
// single read port of the previous-sweep memory, then one step each to form the
// differences, multiply, sum and write back. A run ends with one done item.
module heat_diffusion_stencil_2d (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_column,
   input  logic signed [31:0]  req_temperature_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_temperature_out,
   output logic                rsp_run_done,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import hds_pkg::*;

   logic [SIZE_W-1:0] grid_size_ff;
   logic [STEP_W-1:0] step_count_ff;
   logic [COEF_W-1:0] coef_x_ff, coef_y_ff;
   logic [TEMP_W-1:0] rdata, out_ff;
   cmd_type cmd;
   logic host_we, host_re, rsp_load;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= SIZE_W'(64);
         step_count_ff <= '0;
         coef_x_ff <= COEF_W'(16384);
         coef_y_ff <= COEF_W'(16384);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_SIZE:  grid_size_ff <= csr_data[SIZE_W-1:0];
            CSR_STEP_COUNT: step_count_ff <= csr_data[STEP_W-1:0];
            CSR_COEF_X:     coef_x_ff <= csr_data[COEF_W-1:0];
            CSR_COEF_Y:     coef_y_ff <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   hds_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_row(req_row), .req_column(req_column),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_run_done(rsp_run_done),
      .grid_size(grid_size_ff), .step_count(step_count_ff), .cmd(cmd),
      .host_we(host_we), .host_re(host_re), .rsp_load(rsp_load)
   );

   hds_datapath u_dp (
      .clock(clock), .cmd(cmd), .host_we(host_we), .host_re(host_re),
      .host_addr({req_row, req_column}), .host_wdata(req_temperature_in),
      .coef_x(coef_x_ff), .coef_y(coef_y_ff), .host_rdata(rdata)
   );

   // Result register: read data; a done item shows zero instead.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_ff <= rdata;
      end
   end

   assign rsp_temperature_out = rsp_run_done ? '0 : out_ff;
endmodule

// File: hw/rtl/hds_datapath.sv
// Datapath of the heat diffusion block: grid memories and stencil arithmetic.
`timescale 1ns / 1ps
module hds_datapath (
   input  logic                         clock,
   input  hds_pkg::cmd_type             cmd,
   input  logic                         host_we,
   input  logic                         host_re,
   input  logic [hds_pkg::ADDR_W-1:0]   host_addr,
   input  logic [hds_pkg::TEMP_W-1:0]   host_wdata,
   input  logic [hds_pkg::COEF_W-1:0]   coef_x,
   input  logic [hds_pkg::COEF_W-1:0]   coef_y,
   output logic [hds_pkg::TEMP_W-1:0]   host_rdata
);
   import hds_pkg::*;

   logic [TEMP_W-1:0] now_mem [GRID*GRID];
   logic [TEMP_W-1:0] bef_mem [GRID*GRID];
   logic [TEMP_W-1:0] now_q_ff;
   logic [TEMP_W-1:0] bef_q_ff;
   logic [ADDR_W-1:0] copy_addr_ff;
   logic signed [TEMP_W-1:0] mid_ff, up_ff, dn_ff, lf_ff;
   logic signed [TEMP_W+1:0] dv_ff, dh_ff;
   logic signed [TEMP_W+COEF_W+2:0] pv_ff, ph_ff;
   logic [TEMP_W-1:0] res_ff;
   logic [ADDR_W-1:0] cell_addr, bef_addr, now_waddr, now_raddr;
   logic [TEMP_W-1:0] now_wdata;
   logic now_we;
   logic signed [TEMP_W+COEF_W+3:0] sum_w;

   assign cell_addr = {cmd.cell_row, cmd.cell_col};

   // Neighbor address for the fetch sequence: middle, up, down, left, right.
   always_comb begin
      case (cmd.fetch_sel)
         3'd0: bef_addr = cell_addr;
         3'd1: bef_addr = cell_addr - ADDR_W'(GRID);
         3'd2: bef_addr = cell_addr + ADDR_W'(GRID);
         3'd3: bef_addr = cell_addr - ADDR_W'(1);
         default: bef_addr = cell_addr + ADDR_W'(1);
      endcase
   end

   // Current grid: host and write-back share the write port.
   assign now_we    = host_we | cmd.write_back;
   assign now_waddr = cmd.write_back ? cell_addr : host_addr;
   assign now_wdata = cmd.write_back ? res_ff : host_wdata;
   assign now_raddr = cmd.copy_rd ? cmd.copy_addr : host_addr;

   always_ff @(posedge clock) begin
      if (now_we) begin
         now_mem[now_waddr] <= now_wdata;
      end
      if (host_re | cmd.copy_rd) begin
         now_q_ff <= now_mem[now_raddr];
      end
      copy_addr_ff <= cmd.copy_addr;
   end

   // Previous sweep copy.
   always_ff @(posedge clock) begin
      if (cmd.copy_wr) begin
         bef_mem[copy_addr_ff] <= now_q_ff;
      end
      if (cmd.fetch) begin
         bef_q_ff <= bef_mem[bef_addr];
      end
   end

   // Capture neighbors one per cycle; data arrives in the cycle after its address, so the
   // right neighbor is still in the read register when the differences are formed.
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         dv_ff <= (TEMP_W+2)'(up_ff) + (TEMP_W+2)'(dn_ff) - ((TEMP_W+2)'(mid_ff) <<< 1);
         dh_ff <= (TEMP_W+2)'(lf_ff) + (TEMP_W+2)'($signed(bef_q_ff))
                  - ((TEMP_W+2)'(mid_ff) <<< 1);
      end else if (cmd.fetch) begin
         case (cmd.fetch_sel)
            3'd1: mid_ff <= $signed(bef_q_ff);
            3'd2: up_ff <= $signed(bef_q_ff);
            3'd3: dn_ff <= $signed(bef_q_ff);
            3'd4: lf_ff <= $signed(bef_q_ff);
            default: ;
         endcase
      end
   end

   // Products, then shifted sum with saturation.
   assign sum_w = (TEMP_W+COEF_W+4)'(mid_ff) + (TEMP_W+COEF_W+4)'(pv_ff >>> 16)
                  + (TEMP_W+COEF_W+4)'(ph_ff >>> 16);
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         pv_ff <= dv_ff * $signed({1'b0, coef_x});
         ph_ff <= dh_ff * $signed({1'b0, coef_y});
      end
      if (cmd.sum) begin
         if (sum_w > (TEMP_W+COEF_W+4)'(32'sh7fffffff)) begin
            res_ff <= 32'h7fffffff;
         end else if (sum_w < -(TEMP_W+COEF_W+4)'(33'sh080000000)) begin
            res_ff <= 32'h80000000;
         end else begin
            res_ff <= sum_w[TEMP_W-1:0];
         end
      end
   end

   assign host_rdata = now_q_ff;
endmodule

// File: hw/rtl/hds_controller.sv
// Controller of the heat diffusion block: item handshake and sweep sequencing.
`timescale 1ns / 1ps
module hds_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [hds_pkg::IDX_W-1:0]   req_row,
   input  logic [hds_pkg::IDX_W-1:0]   req_column,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_run_done,
   input  logic [hds_pkg::SIZE_W-1:0]  grid_size,
   input  logic [hds_pkg::STEP_W-1:0]  step_count,
   output hds_pkg::cmd_type            cmd,
   output logic                        host_we,
   output logic                        host_re,
   output logic                        rsp_load
);
   import hds_pkg::*;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] caddr_ff, caddr_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [2:0] sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in, done_ff, done_in;
   logic [SIZE_W-1:0] n_eff;
   logic accept, out_free, last_row, last_col;

   assign n_eff = (grid_size > SIZE_W'(GRID)) ? SIZE_W'(GRID) : grid_size;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept = req_valid && !req_stall;
   assign last_row = (SIZE_W'(row_ff) + SIZE_W'(2)) >= n_eff;
   assign last_col = (SIZE_W'(col_ff) + SIZE_W'(2)) >= n_eff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_READ) begin
               state_in = ST_READ;
            end else if (accept && req_operation == OP_RUN) begin
               state_in = (step_count == '0 || n_eff < SIZE_W'(3)) ? ST_DONE : ST_COPY;
            end
         end
         ST_READ:    state_in = ST_IDLE;
         ST_COPY:    if (&caddr_ff) state_in = ST_CP_LAST;
         ST_CP_LAST: state_in = ST_FETCH;
         ST_FETCH:   if (sel_ff == 3'd4) state_in = ST_CALC;
         ST_CALC:    state_in = ST_MUL;
         ST_MUL:     state_in = ST_SUM;
         ST_SUM:     state_in = ST_WRITE;
         ST_WRITE: begin
            if (!(last_row && last_col)) state_in = ST_FETCH;
            else if (step_ff == STEP_W'(1)) state_in = ST_DONE;
            else state_in = ST_COPY;
         end
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      cmd = '0;
      cmd.copy_addr = caddr_ff;
      cmd.cell_row = row_ff;
      cmd.cell_col = col_ff;
      cmd.fetch_sel = sel_ff;
      host_we = 1'b0;
      host_re = 1'b0;
      rsp_load = 1'b0;
      step_in = step_ff;
      caddr_in = caddr_ff;
      row_in = row_ff;
      col_in = col_ff;
      sel_in = sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      done_in = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.cell_row = req_row;
            cmd.cell_col = req_column;
            host_we = accept && req_operation == OP_WRITE;
            host_re = accept && req_operation == OP_READ;
            step_in = step_count;
            caddr_in = '0;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            done_in = 1'b0;
            rsp_load = 1'b1;
         end
         ST_COPY: begin
            cmd.copy_rd = 1'b1;
            cmd.copy_wr = caddr_ff != '0;
            caddr_in = caddr_ff + ADDR_W'(1);
            row_in = IDX_W'(1);
            col_in = IDX_W'(1);
            sel_in = 3'd0;
         end
         ST_CP_LAST: cmd.copy_wr = 1'b1;
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            sel_in = sel_ff + 3'd1;
         end
         ST_CALC: cmd.calc = 1'b1;
         ST_MUL:  cmd.mul = 1'b1;
         ST_SUM:  cmd.sum = 1'b1;
         ST_WRITE: begin
            cmd.write_back = 1'b1;
            sel_in = 3'd0;
            if (last_col) begin
               col_in = IDX_W'(1);
               row_in = row_ff + IDX_W'(1);
            end else begin
               col_in = col_ff + IDX_W'(1);
            end
            if (last_row && last_col) step_in = step_ff - STEP_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               done_in = 1'b1;
               rsp_load = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      caddr_ff <= caddr_in;
      row_ff <= row_in;
      col_ff <= col_in;
      sel_ff <= sel_in;
      done_ff <= done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_run_done = done_ff;
endmodule

// File: hw/rtl/hds_checker.sv
// Port-level checker for the heat diffusion block and its bind.
`timescale 1ns / 1ps
`include "heat_diffusion_stencil_2d_macros.svh"
module hds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_run_done,
   input logic [31:0] rsp_temperature_out
);
   import hds_pkg::*;

   `HDS_ASSERT_IMP(done_zero, clock, reset, rsp_valid && rsp_run_done, rsp_temperature_out == 32'd0)
   `HDS_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `HDS_ASSERT_NEXT(read_busy, clock, reset, req_valid && !req_stall && req_operation == OP_READ, req_stall)
   `HDS_ASSERT_NEXT(write_free, clock, reset, req_valid && !req_stall && req_operation == OP_WRITE && !rsp_valid, !req_stall)
endmodule

bind heat_diffusion_stencil_2d hds_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_run_done(rsp_run_done), .rsp_temperature_out(rsp_temperature_out)
);

// File: tb/sv/tb_heat_diffusion_stencil_2d.sv
// Self-checking testbench for the two-dimensional heat diffusion block.
`timescale 1ns / 1ps
module tb_heat_diffusion_stencil_2d;
   import hds_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int CELLS = GRID * GRID;
   // Rows and columns below SPAN are filled first; all traffic but the corner items of the edge test stays inside them.
   localparam int SPAN = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_WRITE;
   logic [5:0] req_row = '0;
   logic [5:0] req_column = '0;
   logic signed [31:0] req_temperature_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_temperature_out;
   logic rsp_run_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_GRID_SIZE;
   logic [31:0] csr_data = '0;

   // Predictor state: both grids and the four registers.
   logic signed [31:0] cells_now [CELLS];
   logic signed [31:0] cells_prev [CELLS];
   logic [6:0] size_reg = 7'd64;
   logic [23:0] steps_reg = '0;
   logic [15:0] cx_reg = 16'd16384;
   logic [15:0] cy_reg = 16'd16384;

   // Expected results, oldest first.
   logic signed [31:0] want_temp [$];
   logic want_done [$];

   int errors = 0;
   bit quiet = 1'b0;
   int hold_start = 0;

   heat_diffusion_stencil_2d dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb_heat_diffusion_stencil_2d: FAIL");
      $finish;
   end

   // One Jacobi sweep over the interior of the n x n grid.
   function automatic void sweep_grid(int n);
      int at;
      longint mid, dv, dh, sum;
      cells_prev = cells_now;
      for (int r = 1; r + 1 < n; r++) begin
         for (int c = 1; c + 1 < n; c++) begin
            at = r * GRID + c;
            mid = cells_prev[at];
            dv = longint'(cells_prev[at - GRID]) + longint'(cells_prev[at + GRID]) - 2 * mid;
            dh = longint'(cells_prev[at - 1]) + longint'(cells_prev[at + 1]) - 2 * mid;
            sum = mid + ((longint'(cx_reg) * dv) >>> 16) + ((longint'(cy_reg) * dh) >>> 16);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            cells_now[at] = sum[31:0];
         end
      end
   endfunction

   // Work out what one accepted item causes.
   function automatic void predict_item(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                                        logic signed [31:0] t);
      int n;
      case (op)
         OP_WRITE: cells_now[r * GRID + c] = t;
         OP_READ: begin
            want_temp.push_back(cells_now[r * GRID + c]);
            want_done.push_back(1'b0);
         end
         OP_RUN: begin
            n = (size_reg > GRID) ? GRID : size_reg;
            for (int s = 0; s < steps_reg; s++) sweep_grid(n);
            want_temp.push_back(32'sd0);
            want_done.push_back(1'b1);
         end
         default: ;
      endcase
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                            logic signed [31:0] t);
      int gap;
      gap = (!quiet && $urandom_range(99) < 37) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_row <= r;
      req_column <= c;
      req_temperature_in <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(op, r, c, t);
   endtask

   // Wait until every result is in and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (want_temp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GRID_SIZE: size_reg = val[6:0];
         CSR_STEP_COUNT: steps_reg = val[23:0];
         CSR_COEF_X: cx_reg = val[15:0];
         default: cy_reg = val[15:0];
      endcase
   endtask

   task automatic set_regs(int gs, int st, int cx, int cy);
      write_reg(CSR_GRID_SIZE, gs);
      write_reg(CSR_STEP_COUNT, st);
      write_reg(CSR_COEF_X, cx);
      write_reg(CSR_COEF_Y, cy);
   endtask

   // Every cell in use gets a value first, so no read ever sees an unwritten cell.
   task automatic test_fill_grid();
      for (int r = 0; r < SPAN; r++)
         for (int c = 0; c < SPAN; c++)
            send_item(OP_WRITE, 6'(r), 6'(c), 32'($urandom() >>> $urandom_range(0, 31)));
      wait_idle();
   endtask

   // Corners, unknown operation, tiny and oversized grids, zero steps.
   task automatic test_edges();
      send_item(OP_WRITE, 6'd0, 6'd0, 32'sh7fffffff);
      send_item(OP_WRITE, 6'd63, 6'd63, 32'sh80000000);
      send_item(OP_READ, 6'd0, 6'd0, 32'sd0);
      send_item(OP_READ, 6'd63, 6'd63, 32'shffffffff);
      send_item(OP_NONE, 6'd5, 6'd5, 32'sh12345678);
      send_item(OP_READ, 6'd5, 6'd5, 32'sd0);
      wait_idle();
      set_regs(2, 3, 16384, 16384);
      send_item(OP_RUN, 6'd0, 6'd0, 32'sd0);
      send_item(OP_READ, 6'd1, 6'd1, 32'sd0);
      wait_idle();
      write_reg(CSR_STEP_COUNT, 32'h00ffffff);
      write_reg(CSR_STEP_COUNT, 32'd0);
      write_reg(CSR_GRID_SIZE, 32'd64);
      send_item(OP_RUN, 6'd0, 6'd0, 32'sd0);
      wait_idle();
      set_regs(127, 0, 0, 0);
      send_item(OP_RUN, 6'd0, 6'd0, 32'sd0);
      send_item(OP_READ, 6'd10, 6'd10, 32'sd0);
      wait_idle();
   endtask

   // Full-scale opposing neighbors with maximum coefficients drive saturation.
   task automatic test_saturation();
      set_regs(5, 1, 65535, 65535);
      send_item(OP_WRITE, 6'd2, 6'd2, 32'sh7fffffff);
      send_item(OP_WRITE, 6'd1, 6'd2, 32'sh80000000);
      send_item(OP_WRITE, 6'd3, 6'd2, 32'sh80000000);
      send_item(OP_WRITE, 6'd2, 6'd1, 32'sh80000000);
      send_item(OP_WRITE, 6'd2, 6'd3, 32'sh80000000);
      send_item(OP_WRITE, 6'd1, 6'd1, 32'sh7fffffff);
      send_item(OP_RUN, 6'd0, 6'd0, 32'sd0);
      send_item(OP_READ, 6'd2, 6'd2, 32'sd0);
      send_item(OP_READ, 6'd1, 6'd1, 32'sd0);
      send_item(OP_READ, 6'd3, 6'd3, 32'sd0);
      wait_idle();
   endtask

   // The receiver holds off while reads keep coming, so the input backs up.
   task automatic test_backpressure();
      hold_start++;
      for (int i = 0; i < 40; i++)
         send_item(OP_READ, 6'($urandom_range(SPAN - 1)), 6'($urandom_range(SPAN - 1)),
                   32'sd0);
      wait_idle();
   endtask

   // Random phases, each with its own register setting.
   task automatic test_random();
      logic [1:0] op;
      logic signed [31:0] t;
      int pick;
      for (int ph = 0; ph < 12; ph++) begin
         quiet = (ph == 7);
         pick = $urandom_range(99);
         set_regs((pick < 10) ? $urandom_range(64, 127) :
                  (pick < 20) ? $urandom_range(0, 2) : $urandom_range(3, SPAN),
                  (pick < 10) ? 0 : $urandom_range(0, 3),
                  $urandom_range(65535), $urandom_range(65535));
         for (int i = 0; i < 100; i++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_WRITE : (pick < 95) ? OP_READ :
                 (pick < 97) ? OP_RUN : OP_NONE;
            pick = $urandom_range(9);
            t = (pick == 0) ? 32'sh7fffffff : (pick == 1) ? 32'sh80000000 :
                (pick < 5) ? $urandom() >>> 12 : $urandom();
            send_item(op, 6'($urandom_range(SPAN - 1)), 6'($urandom_range(SPAN - 1)), t);
         end
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   // Result side: random stall, plus a long counted hold on request.
   initial begin : stall_driver
      int hold_cnt;
      int hold_seen;
      hold_cnt = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_start != hold_seen) begin
            hold_seen = hold_start;
            hold_cnt = 300;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 37);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_temp.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            if (rsp_temperature_out !== want_temp[0]) begin
               $error("temperature_out expected %0d actual %0d", want_temp[0],
                      rsp_temperature_out);
               errors++;
            end
            if (rsp_run_done !== want_done[0]) begin
               $error("run_done expected %0d actual %0d", want_done[0], rsp_run_done);
               errors++;
            end
            void'(want_temp.pop_front());
            void'(want_done.pop_front());
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_grid();
      test_edges();
      test_saturation();
      test_backpressure();
      test_random();
      wait_idle();
      if (want_temp.size() != 0) begin
         $error("%0d expected result items never arrived", want_temp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb_heat_diffusion_stencil_2d: PASS");
      end else begin
         $display("tb_heat_diffusion_stencil_2d: FAIL");
      end
      $finish;
   end
endmodule
